// ===== src/sul_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sul_pkg: shared types and constants of the link setup block
// Holds the frame constants, the operation and status codes, the
// configuration record and the command record passed through the queue.
// ----------------------------------------------------------------------------
package sul_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int C_CMP_W     = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    localparam logic [7:0] C_FLAG       = 8'h7E;
    localparam logic [3:0] C_ATT_MAX    = 4'd15;
    localparam int         C_Q_DEPTH    = 4;
    localparam int         C_Q_AW       = $clog2(C_Q_DEPTH);
    localparam int         C_PADDR_W    = 5;

    typedef enum logic [2:0] {
        BEAT_OPEN  = 3'd0,
        BEAT_ADDR  = 3'd1,
        BEAT_CTRL  = 3'd2,
        BEAT_BCC   = 3'd3,
        BEAT_CLOSE = 3'd4
    } t_beat;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        LK_IDLE = 2'd0,
        LK_WAIT = 2'd1,
        LK_CONN = 2'd2,
        LK_FAIL = 2'd3
    } t_link;

    typedef enum logic [2:0] {
        REG_ADDRESS  = 3'd0,
        REG_SET_CTRL = 3'd1,
        REG_UA_CTRL  = 3'd2,
        REG_TIMEOUT  = 3'd3,
        REG_MAX_ATT  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  address_byte;
        logic [7:0]  set_control;
        logic [7:0]  ua_control;
        logic [15:0] timeout_ticks;
        logic [3:0]  max_attempts;
    } t_cfg;

    typedef struct packed {
        logic       is_frame;
        t_link      status;
        logic [7:0] addr;
        logic [7:0] ctrl;
    } t_cmd;

endpackage
`default_nettype wire

// ===== src/sul_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sul_cfg: configuration registers
// APB-style register file holding the frame fields, the timeout and the
// retry limit.
// ----------------------------------------------------------------------------
module sul_cfg
    import sul_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [C_PADDR_W-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output t_cfg                      o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[C_PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_ADDRESS:  n_cfg.address_byte  = pwdata[7:0];
                REG_SET_CTRL: n_cfg.set_control   = pwdata[7:0];
                REG_UA_CTRL:  n_cfg.ua_control    = pwdata[7:0];
                REG_TIMEOUT:  n_cfg.timeout_ticks = pwdata[15:0];
                REG_MAX_ATT:  n_cfg.max_attempts  = pwdata[3:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ADDRESS:  prdata = {24'd0, r_cfg.address_byte};
            REG_SET_CTRL: prdata = {24'd0, r_cfg.set_control};
            REG_UA_CTRL:  prdata = {24'd0, r_cfg.ua_control};
            REG_TIMEOUT:  prdata = {16'd0, r_cfg.timeout_ticks};
            REG_MAX_ATT:  prdata = {28'd0, r_cfg.max_attempts};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_byte  <= 8'd3;
            r_cfg.set_control   <= 8'd3;
            r_cfg.ua_control    <= 8'd7;
            r_cfg.timeout_ticks <= 16'd3;
            r_cfg.max_attempts  <= 4'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ===== src/sul_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sul_front: item classifier and handshake state
// Takes each item while the queue is not full, runs the UA recognizer, the
// timeout counter and the attempt count, and queues a frame or status command.
// ----------------------------------------------------------------------------
module sul_front
    import sul_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_FLAG  = 3'd1,
        PH_ADDR  = 3'd2,
        PH_CTRL  = 3'd3,
        PH_BCC   = 3'd4
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_tick, n_tick;
    logic [3:0]             r_att, n_att;
    t_link                  r_link, n_link;
    logic                   w_frame;
    logic                   w_fire;
    logic                   w_accept;
    logic [7:0]             w_bcc;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_bcc      = i_cfg.address_byte ^ i_cfg.ua_control;

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_att   = r_att;
        n_link  = r_link;
        w_frame = 1'b0;
        w_fire  = 1'b0;
        case (t_op'(i_operation))
            OP_START: begin
                n_att   = 4'd0;
                w_frame = 1'b1;
            end
            OP_BYTE: begin
                if (r_link == LK_WAIT) begin
                    case (r_phase)
                        PH_START: begin
                            if (i_rx_byte == C_FLAG) n_phase = PH_FLAG;
                        end
                        PH_FLAG: begin
                            if (i_rx_byte == i_cfg.address_byte) n_phase = PH_ADDR;
                            else if (i_rx_byte != C_FLAG) n_phase = PH_START;
                        end
                        PH_ADDR: begin
                            if (i_rx_byte == i_cfg.ua_control) n_phase = PH_CTRL;
                            else if (i_rx_byte == C_FLAG) n_phase = PH_FLAG;
                            else n_phase = PH_START;
                        end
                        PH_CTRL: begin
                            if (i_rx_byte == w_bcc) n_phase = PH_BCC;
                            else if (i_rx_byte == C_FLAG) n_phase = PH_FLAG;
                            else n_phase = PH_START;
                        end
                        PH_BCC: begin
                            n_phase = PH_START;
                            if (i_rx_byte == C_FLAG) begin
                                n_link = LK_CONN;
                                n_tick = '0;
                            end
                        end
                        default: n_phase = PH_START;
                    endcase
                end
            end
            OP_TICK: begin
                if (r_link == LK_WAIT) begin
                    if (r_tick != '1) n_tick = r_tick + 1'b1;
                    w_fire = (C_CMP_W'(n_tick) >= C_CMP_W'(i_cfg.timeout_ticks))
                             || (n_tick == '1);
                    if (w_fire) begin
                        n_tick = '0;
                        if (r_att != C_ATT_MAX) n_att = r_att + 4'd1;
                        if (n_att < i_cfg.max_attempts) begin
                            w_frame = 1'b1;
                        end else begin
                            n_link  = LK_FAIL;
                            n_phase = PH_START;
                        end
                    end
                end
            end
            default: n_link = r_link;
        endcase
        if (w_frame) begin
            n_link  = LK_WAIT;
            n_phase = PH_START;
            n_tick  = '0;
        end
    end

    assign o_push         = w_accept;
    assign o_cmd.is_frame = w_frame;
    assign o_cmd.status   = n_link;
    assign o_cmd.addr     = i_cfg.address_byte;
    assign o_cmd.ctrl     = i_cfg.set_control;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_tick  <= '0;
            r_att   <= 4'd0;
            r_link  <= LK_IDLE;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_att   <= n_att;
            r_link  <= n_link;
        end
    end

endmodule
`default_nettype wire

// ===== src/sul_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sul_queue: command queue
// Short first-in first-out queue of commands from the front to the back.
// ----------------------------------------------------------------------------
module sul_queue
    import sul_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd              r_mem [C_Q_DEPTH];
    logic [C_Q_AW-1:0] r_wr_ptr;
    logic [C_Q_AW-1:0] r_rd_ptr;
    logic [C_Q_AW:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == (C_Q_AW+1)'(C_Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (w_push && !w_pop) r_count <= r_count + 1'b1;
            else if (w_pop && !w_push) r_count <= r_count - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== src/sul_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sul_back: result sequencer
// Pops commands and emits either the five SET frame bytes, one per cycle while the
// output is ready, or a single status result, through a registered output stage.
// ----------------------------------------------------------------------------
module sul_back
    import sul_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_cmd       i_q_cmd,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_tx_byte,
    output logic            o_tx_valid,
    output logic [1:0]      o_link_status,
    output logic            o_last
);

    t_cmd       r_cmd;
    t_beat      r_beat;
    logic       r_active;
    logic       r_out_valid;
    logic [7:0] r_tx_byte;
    logic       r_tx_valid;
    t_link      r_status;
    logic       r_last;
    logic       w_load;
    logic       w_go;
    t_cmd       w_cmd;
    t_beat      w_beat;
    logic [7:0] w_byte;
    logic       w_more;

    assign w_load = !r_out_valid || i_out_ready;
    assign w_go   = w_load && (r_active || i_q_valid);
    assign o_pop  = w_load && !r_active && i_q_valid;
    assign w_cmd  = r_active ? r_cmd : i_q_cmd;
    assign w_beat = r_active ? r_beat : BEAT_OPEN;
    assign w_more = w_cmd.is_frame && (w_beat != BEAT_CLOSE);

    always_comb begin
        case (w_beat)
            BEAT_OPEN:  w_byte = C_FLAG;
            BEAT_ADDR:  w_byte = w_cmd.addr;
            BEAT_CTRL:  w_byte = w_cmd.ctrl;
            BEAT_BCC:   w_byte = w_cmd.addr ^ w_cmd.ctrl;
            BEAT_CLOSE: w_byte = C_FLAG;
            default:    w_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_beat      <= BEAT_OPEN;
        end else if (w_load) begin
            r_out_valid <= w_go;
            if (w_go) begin
                r_active <= w_more;
                r_beat   <= t_beat'(w_beat + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (w_go) begin
            r_tx_byte  <= w_cmd.is_frame ? w_byte : 8'd0;
            r_tx_valid <= w_cmd.is_frame;
            r_status   <= w_cmd.is_frame ? LK_WAIT : w_cmd.status;
            r_last     <= !w_more;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_tx_valid    = r_tx_valid;
    assign o_link_status = r_status;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_frame_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_tx_valid |-> r_status == LK_WAIT)
        else $error("Frame byte shown without the waiting status.");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_tx_valid |-> r_last && (r_tx_byte == 8'd0))
        else $error("Status result is not a single final item.");

    a_active_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_cmd.is_frame && r_out_valid && !r_last)
        else $error("Sequencer busy outside a frame.");

    a_beat_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && w_load |=> r_out_valid && r_tx_valid)
        else $error("Frame interrupted before its last byte.");
`endif

endmodule
`default_nettype wire

// ===== src/set_ua_link_setup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_ua_link_setup: SET/UA link setup handshake, transmitter side
// A start item, or a tick that reaches the timeout with attempts left, yields
// the five SET frame bytes as five result items, one per cycle while the output
// is ready; every other item yields one status item. The front takes one item
// per cycle while the queue is not full and stays ahead of the output by up to
// four queued commands; the sustained rate is set by the single byte-wide output
// port of the result sequencer: five result items per frame item, one per status.
// ----------------------------------------------------------------------------
module set_ua_link_setup
    import sul_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_operation,
    input  wire logic [7:0]           i_rx_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [7:0]                o_tx_byte,
    output logic                      o_tx_valid,
    output logic [1:0]                o_link_status,
    output logic                      o_last,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [C_PADDR_W-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    t_cfg w_cfg;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_head_valid;

    sul_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sul_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    sul_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd)
    );

    sul_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_head_valid),
        .i_q_cmd       (w_head_cmd),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_tx_byte     (o_tx_byte),
        .o_tx_valid    (o_tx_valid),
        .o_link_status (o_link_status),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the SET/UA link setup block
// Drives start, received-byte and tick items through the valid/ready input,
// programs the five registers over the APB-style port between phases, and
// checks every result item against a cycle-free model of the handshake kept
// in a scoreboard. Both sides stall at random, and the receiver once holds
// off long enough for the block to back up and stall its input.
// ----------------------------------------------------------------------------
module testbench;
    import sul_pkg::*;

    localparam logic [1:0]   OP_UNUSED     = 2'd3;
    localparam int           STALL_LIMIT   = 2000;
    localparam int           HOLD_CYCLES   = 60;
    localparam int           SETTLE_CYCLES = 12;
    localparam int unsigned  TICK_MAX      = (TIMER_WIDTH >= 32) ? 32'hFFFF_FFFF
                                             : (32'd1 << TIMER_WIDTH) - 32'd1;
    localparam logic [87:0]  NOISY_UA      = 88'h7E_03_07_55_7E_03_7E_03_07_04_7E;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_FLAG,
        RX_ADDR,
        RX_CTRL,
        RX_BCC
    } t_ua_phase;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        t_link      status;
        logic       last;
    } t_tx_result;

    class link_handshake_tracker;
        t_cfg        cfg;
        t_ua_phase   ua_phase;
        int unsigned ticks;
        logic [3:0]  attempts;
        t_link       link;
        t_tx_result  due_outputs[$];
        int          errors;
        int          checked;
        int          accepted;
        int          live_items;
        int          frames;
        int          connects;
        int          failures;

        function new();
            cfg = '{address_byte: 8'd3, set_control: 8'd3, ua_control: 8'd7,
                    timeout_ticks: 16'd3, max_attempts: 4'd3};
            ua_phase = RX_HUNT;
            ticks = 0;
            attempts = '0;
            link = LK_IDLE;
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_ADDRESS:  cfg.address_byte  = value[7:0];
                REG_SET_CTRL: cfg.set_control   = value[7:0];
                REG_UA_CTRL:  cfg.ua_control    = value[7:0];
                REG_TIMEOUT:  cfg.timeout_ticks = value[15:0];
                REG_MAX_ATT:  cfg.max_attempts  = value[3:0];
                default: ;
            endcase
        endfunction

        function void queue_set_frame();
            logic [7:0] frame [5];
            frame = '{C_FLAG, cfg.address_byte, cfg.set_control,
                      cfg.address_byte ^ cfg.set_control, C_FLAG};
            link = LK_WAIT;
            ua_phase = RX_HUNT;
            ticks = 0;
            frames++;
            for (int k = 0; k < 5; k++) begin
                due_outputs.push_back('{frame[k], 1'b1, LK_WAIT, k == 4});
            end
        endfunction

        // The expected field is tested ahead of the flag in the flag, address and control phases.
        function void track_ua_byte(logic [7:0] b);
            case (ua_phase)
                RX_HUNT: begin
                    if (b == C_FLAG) ua_phase = RX_FLAG;
                end
                RX_FLAG: begin
                    if (b == cfg.address_byte) ua_phase = RX_ADDR;
                    else if (b != C_FLAG) ua_phase = RX_HUNT;
                end
                RX_ADDR: begin
                    if (b == cfg.ua_control) ua_phase = RX_CTRL;
                    else if (b == C_FLAG) ua_phase = RX_FLAG;
                    else ua_phase = RX_HUNT;
                end
                RX_CTRL: begin
                    if (b == (cfg.address_byte ^ cfg.ua_control)) ua_phase = RX_BCC;
                    else if (b == C_FLAG) ua_phase = RX_FLAG;
                    else ua_phase = RX_HUNT;
                end
                default: begin
                    ua_phase = RX_HUNT;
                    if (b == C_FLAG) begin
                        link = LK_CONN;
                        ticks = 0;
                        connects++;
                    end
                end
            endcase
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] b);
            accepted++;
            if (op == OP_START) begin
                attempts = '0;
                live_items++;
                queue_set_frame();
                return;
            end
            if (op == OP_BYTE && link == LK_WAIT) begin
                live_items++;
                track_ua_byte(b);
            end else if (op == OP_TICK && link == LK_WAIT) begin
                live_items++;
                if (ticks < TICK_MAX) ticks++;
                if (ticks >= cfg.timeout_ticks || ticks == TICK_MAX) begin
                    ticks = 0;
                    if (attempts < C_ATT_MAX) attempts++;
                    if (attempts < cfg.max_attempts) begin
                        queue_set_frame();
                        return;
                    end
                    link = LK_FAIL;
                    ua_phase = RX_HUNT;
                    failures++;
                end
            end
            due_outputs.push_back('{8'h00, 1'b0, link, 1'b1});
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_output(logic [7:0] tx_byte, logic tx_valid, logic [1:0] status,
                          logic last);
            t_tx_result want;
            if (due_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected item byte %02h valid %0b status %0d",
                                          tx_byte, tx_valid, status));
                return;
            end
            want = due_outputs.pop_front();
            checked++;
            if (tx_byte !== want.tx_byte)
                report_mismatch($sformatf("item %0d tx_byte %02h, want %02h",
                                          checked, tx_byte, want.tx_byte));
            if (tx_valid !== want.tx_valid)
                report_mismatch($sformatf("item %0d tx_valid %0b, want %0b",
                                          checked, tx_valid, want.tx_valid));
            if (status !== want.status)
                report_mismatch($sformatf("item %0d link_status %0d, want %0d",
                                          checked, status, want.status));
            if (last !== want.last)
                report_mismatch($sformatf("item %0d last %0b, want %0b",
                                          checked, last, want.last));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_operation;
    logic [7:0]           i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [7:0]           o_tx_byte;
    logic                 o_tx_valid;
    logic [1:0]           o_link_status;
    logic                 o_last;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [C_PADDR_W-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    link_handshake_tracker tracker = new();
    bit hold_request = 1'b0;
    bit steady_tail  = 1'b0;
    int idle_cycles  = 0;
    int settings_used = 1;

    set_ua_link_setup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_tx_byte     (o_tx_byte),
        .o_tx_valid    (o_tx_valid),
        .o_link_status (o_link_status),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) tracker.note_item(i_operation, i_rx_byte);
            if (o_out_valid && i_out_ready)
                tracker.check_output(o_tx_byte, o_tx_valid, o_link_status, o_last);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no item moved for %0d cycles", STALL_LIMIT);
                $display("set_ua_link_setup regression: fail");
                $finish;
            end
        end
    end

    initial begin
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] value);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_rx_byte   <= value;
        do @(posedge i_clk); while (!o_in_ready);
        if (!steady_tail && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_ua(input int bad_pos);
        logic [7:0] frame [5];
        frame = '{C_FLAG, tracker.cfg.address_byte, tracker.cfg.ua_control,
                  tracker.cfg.address_byte ^ tracker.cfg.ua_control, C_FLAG};
        if (bad_pos >= 0) frame[bad_pos] ^= 8'($urandom_range(1, 255));
        for (int k = 0; k < 5; k++) send_item(OP_BYTE, frame[k]);
    endtask

    task automatic run_episode();
        int steps;
        int pick;
        send_item(OP_START, 8'($urandom));
        steps = $urandom_range(2, 10);
        repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) send_item(OP_TICK, 8'($urandom));
            else if (pick < 62) send_ua(-1);
            else if (pick < 70) send_ua($urandom_range(0, 4));
            else if (pick < 90) send_item(OP_BYTE, 8'($urandom));
            else if (pick < 95) send_item(OP_START, 8'($urandom));
            else send_item(OP_UNUSED, 8'($urandom));
        end
    endtask

    task automatic random_phase(input int count);
        int target;
        target = tracker.accepted + count;
        while (tracker.accepted < target) run_episode();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.due_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(input logic [7:0] address, input logic [7:0] set_ctrl,
                                 input logic [7:0] ua_ctrl, input logic [15:0] timeout,
                                 input logic [3:0] max_att);
        apb_write(REG_ADDRESS, {24'd0, address});
        apb_write(REG_SET_CTRL, {24'd0, set_ctrl});
        apb_write(REG_UA_CTRL, {24'd0, ua_ctrl});
        apb_write(REG_TIMEOUT, {16'd0, timeout});
        apb_write(REG_MAX_ATT, {28'd0, max_att});
        settings_used++;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= OP_START;
        i_rx_byte   <= 8'h00;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_TICK, 8'hFF);
        send_item(OP_START, 8'h00);
        send_ua(-1);
        send_item(OP_BYTE, 8'h7E);
        send_item(OP_TICK, 8'h00);
        send_item(OP_UNUSED, 8'hA5);
        send_item(OP_START, 8'h5A);
        repeat (3) send_item(OP_TICK, 8'h00);
        for (int k = 0; k < 11; k++) send_item(OP_BYTE, NOISY_UA[87 - 8 * k -: 8]);
        random_phase(20);
        drain();

        load_settings(8'h00, 8'h00, 8'h00, 16'd1, 4'd1);
        hold_request = 1'b1;
        random_phase(25);
        drain();

        load_settings(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 4'hF);
        random_phase(20);
        drain();

        load_settings(C_FLAG, C_FLAG, C_FLAG, 16'd0, 4'd0);
        send_item(OP_START, 8'hC3);
        send_ua(-1);
        send_item(OP_START, 8'h3C);
        send_item(OP_TICK, 8'h81);
        random_phase(15);
        drain();

        load_settings(8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom_range(1, 4)), 4'($urandom_range(1, 15)));
        random_phase(25);
        drain();

        steady_tail = 1'b1;
        load_settings(8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom_range(1, 4)), 4'($urandom_range(1, 15)));
        random_phase(30);
        drain();

        if (tracker.due_outputs.size() != 0)
            tracker.report_mismatch($sformatf("%0d expected items never came",
                                              tracker.due_outputs.size()));
        $display("Covered %0d live items under %0d register settings: %0d SET frames,",
                 tracker.live_items, settings_used, tracker.frames);
        $display("%0d links connected, %0d links given up, %0d result items checked.",
                 tracker.connects, tracker.failures, tracker.checked);
        if (tracker.errors == 0) begin
            $display("set_ua_link_setup regression: pass");
        end else begin
            $display("set_ua_link_setup regression: fail");
        end
        $finish;
    end

endmodule

// ===== set_ua_link_setup.f =====
src/sul_pkg.sv
src/sul_cfg.sv
src/sul_front.sv
src/sul_queue.sv
src/sul_back.sv
src/set_ua_link_setup.sv
dv/testbench.sv
